// ===== sv/lmsci_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the latency mean / stddev / interval block.
// No dependencies.
package lmsci_pkg;

  localparam int SAMPLE_W = 24;   // widest saturated sample
  localparam int SUM_W    = 36;
  localparam int SQ_W     = 60;
  localparam int CNT_W    = 13;
  localparam int Z_W      = 12;
  localparam logic [Z_W-1:0] Z_RESET = 12'd502;  // 1.96 in Q4.8

  localparam int Q_DEPTH  = 4;

  // back end datapath widths
  localparam int MW       = 90;   // multiplicand / product / dividend
  localparam int MPW      = 45;   // multiplier
  localparam int DIVW     = 30;   // divisor and remainder
  localparam int RT_W     = 45;   // square root
  localparam int SQR_W    = 48;   // square root remainder
  localparam int DIV_STEPS = MW;
  localparam int SQ_STEPS  = MW / 2;
  localparam int DCNT_W   = $clog2(DIV_STEPS + 1);
  localparam int SCNT_W   = $clog2(SQ_STEPS + 1);

  localparam logic [33:0] HIGH_MAX = 34'h3_FFFF_FFFF;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [SQ_W-1:0]  sumsq;
    logic [CNT_W-1:0] cnt;
  } acc_entry_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_NSQ,
    BK_MUL_SS,
    BK_MUL_NN,
    BK_DIV_MEAN,
    BK_DIV_VAR,
    BK_SQRT_SD,
    BK_MUL_ZS,
    BK_MUL_ZZ,
    BK_DIV_MRG,
    BK_SQRT_MRG,
    BK_OUT
  } bk_state_t;

endpackage

// ===== sv/lmsci_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for samples and results.
// Depends on nothing but the port widths of the block.
interface lmsci_sample_if;
  logic        valid;
  logic        ready;
  logic [31:0] latency_ns;
  logic        last_sample;
  modport source (output valid, output latency_ns, output last_sample, input ready);
  modport sink   (input valid, input latency_ns, input last_sample, output ready);
endinterface

interface lmsci_result_if;
  logic               valid;
  logic               ready;
  logic [31:0]        mean_value;
  logic [31:0]        std_deviation;
  logic signed [33:0] interval_low;
  logic [33:0]        interval_high;
  logic [12:0]        sample_count;
  modport source (output valid, output mean_value, output std_deviation,
                  output interval_low, output interval_high, output sample_count,
                  input ready);
  modport sink   (input valid, input mean_value, input std_deviation,
                  input interval_low, input interval_high, input sample_count,
                  output ready);
endinterface

// ===== sv/latency_mean_stddev_interval_core.sv =====
`timescale 1ns / 1ps
// Latency statistics: one sample per cycle into the accumulating front end
// while the queue has room. Each closed set is worked in the back end by the
// bit-serial multiplier, three 90-step divisions and two 45-step square roots.
// A four-entry queue holds closed sets. Synchronous reset clears accumulators,
// queue and sequencer; z returns to 1.96.
module latency_mean_stddev_interval_core #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                           clk,
  input  logic                           rst,
  lmsci_sample_if.sink                   sample_ch,
  lmsci_result_if.source                 result_ch,
  input  logic                           cfg_we,
  input  logic [lmsci_pkg::Z_W-1:0]      cfg_wdata
);
  import lmsci_pkg::*;

  logic       room;
  logic       push;
  acc_entry_t push_data;
  logic       q_valid;
  acc_entry_t q_data;
  logic       q_pop;
  logic [Z_W-1:0] z_factor;

  always_ff @(posedge clk) begin
    if (rst)         z_factor <= Z_RESET;
    else if (cfg_we) z_factor <= cfg_wdata;
  end

  lmsci_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk(clk), .rst(rst), .sample_ch(sample_ch), .room(room),
    .push(push), .push_data(push_data)
  );

  lmsci_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_data(push_data), .pop(q_pop),
    .q_valid(q_valid), .q_data(q_data), .room(room)
  );

  lmsci_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data), .q_pop(q_pop),
    .z_factor(z_factor), .result_ch(result_ch)
  );

endmodule

// ===== sv/lmsci_queue.sv =====
`timescale 1ns / 1ps
// Small register queue of finished sample sets between front and back end.
// Depends on lmsci_pkg.
module lmsci_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lmsci_pkg::acc_entry_t push_data,
  input  logic                pop,
  output logic                q_valid,
  output lmsci_pkg::acc_entry_t q_data,
  output logic                room
);
  import lmsci_pkg::*;

  localparam int AW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int CW = $clog2(Q_DEPTH + 1);

  acc_entry_t    mem [Q_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    if (p == AW'(Q_DEPTH - 1)) return '0;
    return p + AW'(1);
  endfunction

  assign q_valid = (count != '0);
  assign q_data  = mem[rd_ptr];
  // one set may still be in the front pipeline, so keep a slot spare
  assign room    = (count <= CW'(Q_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)  rd_ptr <= ptr_inc(rd_ptr);
      if (push && !pop)      count <= count + CW'(1);
      else if (!push && pop) count <= count - CW'(1);
    end
  end

endmodule

// ===== sv/lmsci_front.sv =====
`timescale 1ns / 1ps
// Front end: saturates samples, squares them and accumulates count, sum and
// sum of squares; on the last sample pushes the set to the queue. Uses lmsci_pkg.
module lmsci_front #(
  parameter int MAX_SAMPLES = 1024,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  lmsci_sample_if.sink          sample_ch,
  input  logic                  room,
  output logic                  push,
  output lmsci_pkg::acc_entry_t push_data
);
  import lmsci_pkg::*;

  localparam logic [SAMPLE_W-1:0] SAT_TOP =
    SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SAMPLES);

  logic                  take;
  logic [SAMPLE_W-1:0]   sat;

  logic                  s1_valid;
  logic                  s1_last;
  logic [SAMPLE_W-1:0]   s1_s;
  logic [2*SAMPLE_W-1:0] s1_sq;

  logic [SUM_W-1:0]      acc_sum;
  logic [SQ_W-1:0]       acc_sq;
  logic [CNT_W-1:0]      acc_cnt;
  logic                  keep;
  logic [SUM_W-1:0]      sum_next;
  logic [SQ_W-1:0]       sq_next;
  logic [CNT_W-1:0]      cnt_next;

  // no request is taken while reset is held
  assign sample_ch.ready = room && !rst;
  assign take = sample_ch.valid && room && !rst;
  assign sat  = (sample_ch.latency_ns > {{(32-SAMPLE_W){1'b0}}, SAT_TOP}) ?
                SAT_TOP : sample_ch.latency_ns[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    s1_s  <= sat;
    s1_sq <= sat * sat;
    s1_last <= sample_ch.last_sample;
  end

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= take;
  end

  // samples beyond the limit are dropped but a last flag still closes the set
  assign keep     = (acc_cnt < CNT_MAX);
  assign sum_next = keep ? acc_sum + SUM_W'(s1_s) : acc_sum;
  assign sq_next  = keep ? acc_sq + SQ_W'(s1_sq) : acc_sq;
  assign cnt_next = keep ? acc_cnt + CNT_W'(1) : acc_cnt;

  assign push            = s1_valid && s1_last;
  assign push_data.sum   = sum_next;
  assign push_data.sumsq = sq_next;
  assign push_data.cnt   = cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_sum <= '0;
      acc_sq  <= '0;
      acc_cnt <= '0;
    end else if (s1_valid) begin
      if (s1_last) begin
        acc_sum <= '0;
        acc_sq  <= '0;
        acc_cnt <= '0;
      end else begin
        acc_sum <= sum_next;
        acc_sq  <= sq_next;
        acc_cnt <= cnt_next;
      end
    end
  end

endmodule

// ===== sv/lmsci_back.sv =====
`timescale 1ns / 1ps
// Back end: sequencer over a shift-add multiplier, restoring divider and
// restoring square root; forms mean, stddev and interval. Uses lmsci_pkg.
module lmsci_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  q_valid,
  input  lmsci_pkg::acc_entry_t q_data,
  output logic                  q_pop,
  input  logic [lmsci_pkg::Z_W-1:0] z_factor,
  lmsci_result_if.source        result_ch
);
  import lmsci_pkg::*;

  bk_state_t state, state_next;
  logic      load;
  logic      out_load;

  // operands of the set being worked on
  logic [SUM_W-1:0] op_sum;
  logic [CNT_W-1:0] op_n;

  // multiplier
  logic [MW-1:0]  m_cand;
  logic [MPW-1:0] m_plier;
  logic [MW-1:0]  m_prod;
  logic           mul_done;

  // divider
  logic [MW-1:0]     d_dvd;
  logic [DIVW-1:0]   d_den;
  logic [DIVW-1:0]   d_rem;
  logic [DCNT_W-1:0] d_cnt;
  logic [DIVW-1:0]   d_rem_sh;
  logic [DIVW:0]     d_diff;
  logic              div_done;

  // square root
  logic [MW-1:0]     s_rad;
  logic [SQR_W-1:0]  s_rem;
  logic [RT_W-1:0]   s_root;
  logic [SCNT_W-1:0] s_cnt;
  logic [SQR_W-1:0]  s_rem_sh;
  logic [SQR_W-1:0]  s_trial;
  logic              s_fit;
  logic              sqrt_done;

  // intermediate results
  logic [MW-1:0]   var_num;
  logic [DIVW-1:0] nn;
  logic [31:0]     mean;
  logic [31:0]     sdev;
  logic [RT_W-1:0] margin;

  logic [RT_W:0]   high_sum;
  logic [RT_W+1:0] low_diff;
  logic [33:0]     high_sat;
  logic [33:0]     low_sat;

  logic        res_valid;
  logic [31:0] res_mean;
  logic [31:0] res_sdev;
  logic [33:0] res_low;
  logic [33:0] res_high;
  logic [12:0] res_cnt;

  assign mul_done  = (m_plier == '0);
  assign div_done  = (d_cnt == '0);
  assign sqrt_done = (s_cnt == '0);

  assign d_rem_sh = {d_rem[DIVW-2:0], d_dvd[MW-1]};
  assign d_diff   = {1'b0, d_rem_sh} - {1'b0, d_den};
  assign s_rem_sh = {s_rem[SQR_W-3:0], s_rad[MW-1:MW-2]};
  assign s_trial  = SQR_W'({s_root, 2'b01});
  assign s_fit    = (s_rem_sh >= s_trial);

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE:     if (q_valid)   state_next = BK_MUL_NSQ;
      BK_MUL_NSQ:  if (mul_done)  state_next = BK_MUL_SS;
      BK_MUL_SS:   if (mul_done)  state_next = BK_MUL_NN;
      BK_MUL_NN:   if (mul_done)  state_next = BK_DIV_MEAN;
      BK_DIV_MEAN: if (div_done)  state_next = BK_DIV_VAR;
      BK_DIV_VAR:  if (div_done)  state_next = BK_SQRT_SD;
      BK_SQRT_SD:  if (sqrt_done) state_next = BK_MUL_ZS;
      BK_MUL_ZS:   if (mul_done)  state_next = BK_MUL_ZZ;
      BK_MUL_ZZ:   if (mul_done)  state_next = BK_DIV_MRG;
      BK_DIV_MRG:  if (div_done)  state_next = BK_SQRT_MRG;
      BK_SQRT_MRG: if (sqrt_done) state_next = BK_OUT;
      BK_OUT:      if (!res_valid || result_ch.ready) state_next = BK_IDLE;
      default:     state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state == BK_IDLE) && q_valid;
    out_load = (state == BK_OUT) && (!res_valid || result_ch.ready);
    load     = (state_next != state);
  end

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  // unit stepping; a load for the next state overrides
  always_ff @(posedge clk) begin
    if (!mul_done) begin
      if (m_plier[0]) m_prod <= m_prod + m_cand;
      m_cand  <= {m_cand[MW-2:0], 1'b0};
      m_plier <= {1'b0, m_plier[MPW-1:1]};
    end
    if (!div_done) begin
      if (!d_diff[DIVW]) d_rem <= d_diff[DIVW-1:0];
      else               d_rem <= d_rem_sh;
      d_dvd <= {d_dvd[MW-2:0], !d_diff[DIVW]};
      d_cnt <= d_cnt - DCNT_W'(1);
    end
    if (!sqrt_done) begin
      s_rem  <= s_fit ? s_rem_sh - s_trial : s_rem_sh;
      s_root <= {s_root[RT_W-2:0], s_fit};
      s_rad  <= {s_rad[MW-3:0], 2'b00};
      s_cnt  <= s_cnt - SCNT_W'(1);
    end

    if (load) begin
      unique case (state_next)
        BK_MUL_NSQ: begin
          m_cand <= MW'(q_data.sumsq); m_plier <= MPW'(q_data.cnt); m_prod <= '0;
        end
        BK_MUL_SS: begin
          m_cand <= MW'(op_sum); m_plier <= MPW'(op_sum); m_prod <= '0;
        end
        BK_MUL_NN: begin
          m_cand <= MW'(op_n); m_plier <= MPW'(op_n); m_prod <= '0;
        end
        BK_DIV_MEAN: begin
          d_dvd <= MW'({op_sum, 8'h00}); d_den <= DIVW'(op_n);
          d_rem <= '0; d_cnt <= DCNT_W'(DIV_STEPS);
        end
        BK_DIV_VAR: begin
          d_dvd <= {var_num[MW-17:0], 16'h0000}; d_den <= nn;
          d_rem <= '0; d_cnt <= DCNT_W'(DIV_STEPS);
        end
        BK_SQRT_SD, BK_SQRT_MRG: begin
          s_rad <= d_dvd; s_rem <= '0; s_root <= '0; s_cnt <= SCNT_W'(SQ_STEPS);
        end
        BK_MUL_ZS: begin
          m_cand <= MW'(s_root[31:0]); m_plier <= MPW'(z_factor); m_prod <= '0;
        end
        BK_MUL_ZZ: begin
          m_cand <= m_prod; m_plier <= m_prod[MPW-1:0]; m_prod <= '0;
        end
        BK_DIV_MRG: begin
          d_dvd <= m_prod; d_den <= DIVW'({op_n, 16'h0000});
          d_rem <= '0; d_cnt <= DCNT_W'(DIV_STEPS);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      op_sum <= q_data.sum;
      op_n   <= q_data.cnt;
    end
    if (load) begin
      unique case (state)
        BK_MUL_NSQ:  var_num <= m_prod;
        BK_MUL_SS:   var_num <= var_num - m_prod;
        BK_MUL_NN:   nn      <= m_prod[DIVW-1:0];
        BK_DIV_MEAN: mean    <= d_dvd[31:0];
        BK_SQRT_SD:  sdev    <= s_root[31:0];
        BK_SQRT_MRG: margin  <= s_root;
        default: begin
        end
      endcase
    end
  end

  // interval with saturation at both ends
  assign high_sum = (RT_W+1)'(mean) + (RT_W+1)'(margin);
  assign low_diff = (RT_W+2)'(mean) - (RT_W+2)'(margin);
  assign high_sat = (high_sum > (RT_W+1)'(HIGH_MAX)) ? HIGH_MAX : high_sum[33:0];
  assign low_sat  = ($signed(low_diff) < -$signed((RT_W+2)'(64'd1 << 33))) ?
                    {1'b1, 33'd0} : low_diff[33:0];

  always_ff @(posedge clk) begin
    if (out_load) begin
      res_mean <= mean;
      res_sdev <= sdev;
      res_low  <= low_sat;
      res_high <= high_sat;
      res_cnt  <= op_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst)                        res_valid <= 1'b0;
    else if (out_load)              res_valid <= 1'b1;
    else if (result_ch.ready)       res_valid <= 1'b0;
  end

  assign result_ch.valid         = res_valid;
  assign result_ch.mean_value    = res_mean;
  assign result_ch.std_deviation = res_sdev;
  assign result_ch.interval_low  = $signed(res_low);
  assign result_ch.interval_high = res_high;
  assign result_ch.sample_count  = res_cnt;

  a_start_needs_set: assert property (@(posedge clk) disable iff (rst)
    (state == BK_IDLE && state_next != BK_IDLE) |-> q_valid)
    else $error("back end started without a queued set");

  a_load_shows: assert property (@(posedge clk) disable iff (rst)
    out_load |=> res_valid)
    else $error("result not presented after load");

  a_low_le_high: assert property (@(posedge clk) disable iff (rst)
    out_load |=> ($signed({1'b0, res_high}) >= $signed({res_low[33], res_low})))
    else $error("interval bounds out of order");

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// Testbench for latency_mean_stddev_interval_core: sends latency samples in sets
// and checks each statistics result against an in-bench integer predictor.
// Depends on lmsci_pkg, the channel interfaces in lmsci_if.sv and the core RTL.
module tb;
  import lmsci_pkg::*;

  localparam int MAX_N = 1024;
  localparam logic [63:0] SAMPLE_TOP = (64'd1 << 24) - 1;
  localparam int SET_DRAIN = 600;

  typedef struct {
    logic [31:0] mean;
    logic [31:0] sdev;
    logic [33:0] lo;
    logic [33:0] hi;
    logic [12:0] n;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [Z_W-1:0] cfg_wdata = '0;

  lmsci_sample_if s_ch ();
  lmsci_result_if r_ch ();

  latency_mean_stddev_interval_core u_top (
    .clk(clk), .rst(rst), .sample_ch(s_ch.sink), .result_ch(r_ch.source),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [63:0] acc_sum, acc_sq, acc_n;
  logic [11:0] z_cur;
  stats_t stats_q[$];
  int errors = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  initial begin
    s_ch.valid = 1'b0;
    s_ch.latency_ns = '0;
    s_ch.last_sample = 1'b0;
    r_ch.ready = 1'b0;
  end

  function automatic logic [63:0] isqrt(logic [127:0] x);
    logic [63:0] root, cand;
    logic [127:0] sq;
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      sq = 128'(cand) * 128'(cand);
      if (sq <= x) root = cand;
    end
    return root;
  endfunction

  // Accumulate one sample; on a last sample push the expected statistics.
  task automatic predict_sample(logic [31:0] lat, logic last);
    logic [63:0] s, n, mean, sdev, margin, high;
    logic signed [63:0] low;
    logic [127:0] d, q, zs;
    stats_t e;
    s = (64'(lat) > SAMPLE_TOP) ? SAMPLE_TOP : 64'(lat);
    if (acc_n < MAX_N) begin
      acc_sum += s;
      acc_sq += s * s;
      acc_n++;
    end
    if (last) begin
      n = acc_n;
      mean = (acc_sum << 8) / n;
      d = 128'(n) * 128'(acc_sq) - 128'(acc_sum) * 128'(acc_sum);
      d = d << 16;
      sdev = isqrt(d / (128'(n) * 128'(n)));
      zs = 128'(z_cur) * 128'(sdev);
      q = (zs * zs) / (128'(n) << 16);
      margin = isqrt(q);
      low = $signed(mean) - $signed(margin);
      if (low < -(64'sd1 <<< 33)) low = -(64'sd1 <<< 33);
      high = mean + margin;
      if (high > 64'h3_FFFF_FFFF) high = 64'h3_FFFF_FFFF;
      e.mean = mean[31:0];
      e.sdev = sdev[31:0];
      e.lo = low[33:0];
      e.hi = high[33:0];
      e.n = n[12:0];
      stats_q.push_back(e);
      acc_sum = 0;
      acc_sq = 0;
      acc_n = 0;
    end
  endtask

  task automatic send_sample(logic [31:0] lat, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_ch.valid <= 1'b0;
      @(posedge clk);
    end
    s_ch.valid <= 1'b1;
    s_ch.latency_ns <= lat;
    s_ch.last_sample <= last;
    do @(posedge clk); while (!s_ch.ready);
    predict_sample(lat, last);
  endtask

  // Idle the sender, wait for every result, then let the back end settle.
  task automatic drain();
    s_ch.valid <= 1'b0;
    @(posedge clk);
    while (stats_q.size() != 0) @(posedge clk);
    repeat (SET_DRAIN) @(posedge clk);
  endtask

  task automatic write_z(logic [11:0] z);
    cfg_we <= 1'b1;
    cfg_wdata <= z;
    @(posedge clk);
    cfg_we <= 1'b0;
    z_cur = z;
  endtask

  // result receiver with random stalls
  always @(posedge clk) begin
    if (rst) begin
      r_ch.ready <= 1'b0;
    end else begin
      r_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && r_ch.valid && r_ch.ready) begin
      if (stats_q.size() == 0) begin
        $display("%0t: unexpected result mean=%h", $time, r_ch.mean_value);
        errors++;
      end else begin
        stats_t e;
        e = stats_q.pop_front();
        if (r_ch.mean_value !== e.mean) begin
          $display("%0t: mean exp %h got %h", $time, e.mean, r_ch.mean_value);
          errors++;
        end
        if (r_ch.std_deviation !== e.sdev) begin
          $display("%0t: stddev exp %h got %h", $time, e.sdev, r_ch.std_deviation);
          errors++;
        end
        if (r_ch.interval_low !== e.lo) begin
          $display("%0t: low exp %h got %h", $time, e.lo, r_ch.interval_low);
          errors++;
        end
        if (r_ch.interval_high !== e.hi) begin
          $display("%0t: high exp %h got %h", $time, e.hi, r_ch.interval_high);
          errors++;
        end
        if (r_ch.sample_count !== e.n) begin
          $display("%0t: count exp %0d got %0d", $time, e.n, r_ch.sample_count);
          errors++;
        end
      end
    end
  end

  task automatic test_directed();
    // single sample at each extreme: zero spread
    send_sample(32'd0, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'h00FF_FFFF, 1'b1);
    // saturation mixed with in-range values
    send_sample(32'h0100_0000, 1'b0);
    send_sample(32'd1, 1'b0);
    send_sample(32'd12345, 1'b1);
    drain();
    // widest margin: both interval bounds saturate
    write_z(12'd4095);
    send_sample(32'd0, 1'b0);
    send_sample(32'hFFFF_FFFF, 1'b1);
    send_sample(32'd100, 1'b0);
    send_sample(32'd300, 1'b1);
    drain();
    write_z(12'd0);
    send_sample(32'd7, 1'b0);
    send_sample(32'h00AB_CDEF, 1'b1);
    drain();
  endtask

  // more than MAX_N samples in one set; the extra ones are dropped
  task automatic test_overflow();
    write_z(Z_RESET);
    for (int i = 0; i < MAX_N + 6; i++)
      send_sample($urandom(), i == MAX_N + 5);
    drain();
  endtask

  task automatic test_random(int items, int idle, int stall, logic [11:0] z);
    int left;
    logic [31:0] lat;
    write_z(z);
    send_idle_pct = idle;
    stall_pct = stall;
    left = 0;
    for (int i = 0; i < items; i++) begin
      if (left == 0) left = ($urandom_range(9) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
      case ($urandom_range(3))
        0: lat = $urandom();
        1: lat = $urandom_range(2000);
        2: lat = SAMPLE_TOP[31:0] - $urandom_range(3);
        default: lat = $urandom_range(32'h00FF_FFFF);
      endcase
      left--;
      send_sample(lat, left == 0 || i == items - 1);
      if (i == items / 2) begin
        // hold off once until everything is out
        s_ch.valid <= 1'b0;
        @(posedge clk);
        while (stats_q.size() != 0) @(posedge clk);
      end
    end
    drain();
  endtask

  initial begin
    acc_sum = 0;
    acc_sq = 0;
    acc_n = 0;
    z_cur = Z_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random(40, 0, 0, 12'd502);
    test_random(40, 49, 0, 12'd4095);
    test_random(40, 0, 49, 12'd0);
    test_random(40, 16, 16, 12'($urandom_range(4095)));
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  initial begin
    #2000000;
    $display("tb: errors");
    $finish;
  end
endmodule
